// File: rtl/core/itpct_pkg.sv
// Package for the idle-timeout page tag store.
// Holds the request and result structs, status and request codes and the reset threshold.
// No dependencies; used by idle_timeout_page_cache_tags.
`default_nettype none

package itpct_pkg;

  // Request kinds.
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_SWEEP  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_LOADED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EVICTED = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  // Idle threshold after reset.
  localparam logic [63:0] IDLE_THRESHOLD_RESET = 64'd300;

  // One request as presented on the command port.
  typedef struct packed {
    logic        req_type;
    logic [31:0] page_number;
    logic [63:0] now_time;
  } req_t;

  // One result as presented on the result port.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [31:0] evicted_page;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/idle_timeout_page_cache_tags.sv
// Fully associative page tag store with idle-timeout eviction, top level.
// An accepted request is held in the request register, and its result strobe comes from the result register.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// The slot compare and priority encoders sit between the request and result registers.
// Reset clears all slot valid bits and sets the idle threshold to 300.
// Depends on itpct_pkg.
`default_nettype none

module idle_timeout_page_cache_tags #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Command channel.
  input  wire logic             start,
  output logic                  busy,
  input  wire itpct_pkg::req_t  req_i,
  // Result channel.
  output logic                  rsp_valid_o,
  output itpct_pkg::rsp_t       rsp_o,
  // Configuration port.
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int IdxW = $clog2(SLOT_COUNT);

  // Lowest set bit of a vector, with a found flag on top.
  function automatic logic [IdxW:0] lowest_set(input logic [SLOT_COUNT-1:0] vec);
    logic [IdxW:0] res;
    res = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (vec[k]) begin
        res = {1'b1, IdxW'(k)};
      end
    end
    return res;
  endfunction

  logic [63:0]           threshold_q;
  logic                  req_valid_q;
  itpct_pkg::req_t       req_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [31:0]           page_q     [SLOT_COUNT];
  logic [63:0]           last_use_q [SLOT_COUNT];
  logic                  rsp_valid_q;
  itpct_pkg::rsp_t       rsp_q;
  itpct_pkg::rsp_t       rsp_d;

  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] evict_vec;
  logic [64:0]           idle_diff [SLOT_COUNT];
  logic [IdxW:0]         hit_enc;
  logic [IdxW:0]         free_enc;
  logic [IdxW:0]         evict_enc;
  logic                  is_access;
  logic                  is_sweep;
  logic                  do_refresh;
  logic                  do_load;
  logic                  do_evict;
  logic                  cfg_write;

  // Requests are taken every cycle.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register write and read-back.
  assign cfg_write = psel && penable && pwrite && pready && (paddr[3] == 1'b0);
  assign prdata    = (paddr[3] == 1'b0) ? threshold_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= itpct_pkg::IDLE_THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold_q <= pwdata;
    end
  end

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // Per-slot match, free and idle-timeout qualification.
  always_comb begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      idle_diff[k] = {1'b0, req_q.now_time} - {1'b0, last_use_q[k]};
      hit_vec[k]   = valid_q[k] && (page_q[k] == req_q.page_number);
      free_vec[k]  = !valid_q[k];
      // A borrow means the clock is behind, so the idle time counts as zero.
      evict_vec[k] = valid_q[k] && (idle_diff[k][64] ? (threshold_q == 64'd0)
                                                     : (idle_diff[k][63:0] >= threshold_q));
    end
  end

  assign hit_enc   = lowest_set(hit_vec);
  assign free_enc  = lowest_set(free_vec);
  assign evict_enc = lowest_set(evict_vec);

  assign is_access  = req_valid_q && (req_q.req_type == itpct_pkg::REQ_ACCESS);
  assign is_sweep   = req_valid_q && (req_q.req_type == itpct_pkg::REQ_SWEEP);
  assign do_refresh = is_access && hit_enc[IdxW];
  assign do_load    = is_access && !hit_enc[IdxW] && free_enc[IdxW];
  assign do_evict   = is_sweep && evict_enc[IdxW];

  // Result selection.
  always_comb begin
    rsp_d = '0;
    if (req_q.req_type == itpct_pkg::REQ_ACCESS) begin
      if (hit_enc[IdxW]) begin
        rsp_d.status     = itpct_pkg::ST_HIT;
        rsp_d.slot_index = 4'(hit_enc[IdxW-1:0]);
      end else if (free_enc[IdxW]) begin
        rsp_d.status     = itpct_pkg::ST_LOADED;
        rsp_d.slot_index = 4'(free_enc[IdxW-1:0]);
      end else begin
        rsp_d.status     = itpct_pkg::ST_FULL;
      end
    end else begin
      if (evict_enc[IdxW]) begin
        rsp_d.status       = itpct_pkg::ST_EVICTED;
        rsp_d.slot_index   = 4'(evict_enc[IdxW-1:0]);
        rsp_d.evicted_page = page_q[evict_enc[IdxW-1:0]];
      end else begin
        rsp_d.status       = itpct_pkg::ST_NONE;
      end
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_load) begin
      valid_q[free_enc[IdxW-1:0]] <= 1'b1;
    end else if (do_evict) begin
      valid_q[evict_enc[IdxW-1:0]] <= 1'b0;
    end
  end

  // Slot page tags and last-use times.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      page_q[free_enc[IdxW-1:0]]     <= req_q.page_number;
      last_use_q[free_enc[IdxW-1:0]] <= req_q.now_time;
    end else if (do_refresh) begin
      last_use_q[hit_enc[IdxW-1:0]]  <= req_q.now_time;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A result strobe always follows a registered request.
  a_rsp_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> $past(req_valid_q))
    else $error("result strobe without a preceding request");

  // A page is held in at most one valid slot.
  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |-> $onehot0(hit_vec))
    else $error("page found in more than one slot");

  // A load grows the number of valid slots by exactly one.
  a_load_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("load did not claim exactly one slot");

  // Only an eviction reports a page.
  a_page_on_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status != itpct_pkg::ST_EVICTED))
      |-> (rsp_q.evicted_page == 32'd0))
    else $error("page reported on a result that is not an eviction");

endmodule

`default_nettype wire
